>>> hdl/tilt_angle_kalman_filter_macros.svh
// Assertion macros for the tilt Kalman filter.
// Expects signals named clk and rst in the including module.
`ifndef TILT_ANGLE_KALMAN_FILTER_MACROS_SVH
`define TILT_ANGLE_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TKF_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tkf assertion failed");

// Next-cycle implication, checked outside reset
`define TKF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tkf assertion failed");

`endif

>>> hdl/tkf_pkg.sv
// Shared constants for the tilt Kalman filter.
// No dependencies.
`default_nettype none
package tkf_pkg;
  localparam int FRAC_BITS = 28;
  localparam int IDX_W     = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_SAMPLE_PERIOD  = 3'd0,
    REG_ANGLE_NOISE    = 3'd1,
    REG_BIAS_NOISE     = 3'd2,
    REG_MEAS_NOISE     = 3'd3,
    REG_OBS_GAIN       = 3'd4
  } tkf_reg_t;

  localparam logic [30:0] RST_SAMPLE_PERIOD = 31'd268435;
  localparam logic [30:0] RST_ANGLE_NOISE   = 31'd268435;
  localparam logic [30:0] RST_BIAS_NOISE    = 31'd1342177;
  localparam logic [30:0] RST_MEAS_NOISE    = 31'd134217728;
  localparam logic signed [31:0] RST_OBS_GAIN = 32'sd268435456;
endpackage
`default_nettype wire

>>> hdl/tkf_mul.sv
// Shared fixed-point multiplier: (a*b) >> 28, truncated toward zero, saturated.
// Four half-width partial products, accumulated in turn. Uses tkf_pkg.
`default_nettype none
module tkf_mul #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAG_WIDTH   = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [MAG_WIDTH-1:0]   a,
  input  wire logic signed [MAG_WIDTH-1:0]   b,
  output logic                               done,
  output logic signed [VALUE_WIDTH-1:0]      result
);
  import tkf_pkg::*;

  localparam int H  = (MAG_WIDTH + 1) / 2;
  localparam int PW = 2 * H;
  localparam int AW = 2 * PW;
  localparam int RW = AW - FRAC_BITS;

  logic [PW-1:0] xa;
  logic [PW-1:0] xb;
  logic          neg;
  logic [AW-1:0] acc;
  logic [1:0]    cnt;
  logic          busy;
  logic          fin;

  logic [MAG_WIDTH-1:0] ua;
  logic [MAG_WIDTH-1:0] ub;
  logic [H-1:0]         pa;
  logic [H-1:0]         pb;
  logic [PW-1:0]        pp;
  logic [AW-1:0]        pp_sh;
  logic [RW-1:0]        r;
  logic [RW-1:0]        lim_pos;
  logic [RW-1:0]        lim_neg;

  // Magnitudes of the operands
  assign ua = a[MAG_WIDTH-1] ? (~a + 1'b1) : a;
  assign ub = b[MAG_WIDTH-1] ? (~b + 1'b1) : b;

  // Pick the half-words for this partial product
  always_comb begin
    pa    = cnt[0] ? xa[PW-1:H] : xa[H-1:0];
    pb    = cnt[1] ? xb[PW-1:H] : xb[H-1:0];
    pp    = PW'(pa) * PW'(pb);
    pp_sh = AW'(pp) << ((cnt[0] ? H : 0) + (cnt[1] ? H : 0));
  end

  // Drop the fraction and saturate
  assign r       = acc[AW-1:FRAC_BITS];
  assign lim_pos = RW'({(VALUE_WIDTH-1){1'b1}});
  assign lim_neg = lim_pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        xa   <= PW'(ua);
        xb   <= PW'(ub);
        neg  <= a[MAG_WIDTH-1] ^ b[MAG_WIDTH-1];
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + pp_sh;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
        if (neg) begin
          result <= (r > lim_neg) ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                  : -$signed(r[VALUE_WIDTH-1:0]);
        end else begin
          result <= (r > lim_pos) ? {1'b0, {(VALUE_WIDTH-1){1'b1}}}
                                  : $signed(r[VALUE_WIDTH-1:0]);
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/tkf_div.sv
// Restoring divider for the gains: (num << 28) / den, den > 0, saturated.
// One quotient bit per cycle. Uses tkf_pkg.
`default_nettype none
module tkf_div #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [VALUE_WIDTH-1:0] num,
  input  wire logic signed [VALUE_WIDTH-1:0] den,
  output logic                               done,
  output logic signed [VALUE_WIDTH-1:0]      quot
);
  import tkf_pkg::*;

  localparam int NW = VALUE_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]          sh;
  logic [NW-1:0]          q;
  logic [VALUE_WIDTH:0]   rem;
  logic [VALUE_WIDTH-1:0] dv;
  logic                   neg;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic                   fin;

  logic [VALUE_WIDTH-1:0] un;
  logic [VALUE_WIDTH:0]   trial;
  logic                   fits;
  logic [NW-1:0]          lim_pos;
  logic [NW-1:0]          lim_neg;

  assign un    = num[VALUE_WIDTH-1] ? (~num + 1'b1) : num;
  assign trial = {rem[VALUE_WIDTH-1:0], sh[NW-1]};
  assign fits  = trial >= {1'b0, dv};
  assign lim_pos = NW'({(VALUE_WIDTH-1){1'b1}});
  assign lim_neg = lim_pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        sh   <= {un, {FRAC_BITS{1'b0}}};
        q    <= '0;
        rem  <= '0;
        dv   <= den;
        neg  <= num[VALUE_WIDTH-1];
        cnt  <= CW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        // shift in one numerator bit, subtract where it fits
        rem <= fits ? (trial - {1'b0, dv}) : trial;
        q   <= {q[NW-2:0], fits};
        sh  <= {sh[NW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
        if (neg) begin
          quot <= (q > lim_neg) ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                : -$signed(q[VALUE_WIDTH-1:0]);
        end else begin
          quot <= (q > lim_pos) ? {1'b0, {(VALUE_WIDTH-1){1'b1}}}
                                : $signed(q[VALUE_WIDTH-1:0]);
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/tilt_angle_kalman_filter.sv
// Two-state tilt Kalman filter (angle and gyro bias) with one shared multiplier
// and one shared divider under a step sequencer. Depends on tkf_pkg, tkf_mul,
// tkf_div and tilt_angle_kalman_filter_macros.svh.
//
// One beat in gives one beat out. The block takes a beat only when its
// sequencer is idle; an item runs fourteen passes through the
// partial-product multiplier and two bit-serial divisions for the gains (the
// divisions are skipped when the innovation variance is not positive). A
// finished result waits in the output register while the next beat is taken.
// Configuration writes are always ready and must only occur while idle.
`default_nettype none
`include "tilt_angle_kalman_filter_macros.svh"
module tilt_angle_kalman_filter #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [tkf_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [31:0]               cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [31:0]        measured_angle,
  input  wire logic signed [31:0]        angular_rate,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [31:0]             estimated_angle,
  output logic signed [31:0]             estimated_rate
);
  import tkf_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int MW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int AW = MW + 3;
  localparam logic signed [AW-1:0] LIM_HI = AW'({(W-1){1'b1}});
  localparam logic signed [AW-1:0] LIM_LO = ~LIM_HI;
  localparam logic signed [AW-1:0] S32_HI = AW'(33'sh0_7FFF_FFFF);
  localparam logic signed [AW-1:0] S32_LO = ~S32_HI;
  localparam logic signed [W-1:0]  COV_ONE = (W > 29) ? W'(64'sd268435456)
                                                      : {1'b0, {(W-1){1'b1}}};

  typedef enum logic [4:0] {
    S_IDLE, S_RB, S_M_ANG, S_ERR, S_M_C00, S_NEG, S_M_C01, S_M_C11,
    S_M_PCT0, S_M_PCT1, S_M_E, S_D_K0, S_D_K1, S_M_T1, S_M_N00, S_M_N01,
    S_M_N10, S_M_N11, S_M_ANG2, S_M_BIAS, S_OUT
  } state_t;

  function automatic logic signed [W-1:0] sat_w(input logic signed [AW-1:0] v);
    if (v > LIM_HI) return LIM_HI[W-1:0];
    else if (v < LIM_LO) return LIM_LO[W-1:0];
    else return v[W-1:0];
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [AW-1:0] v);
    if (v > S32_HI) return S32_HI[31:0];
    else if (v < S32_LO) return S32_LO[31:0];
    else return v[31:0];
  endfunction

  function automatic logic signed [AW-1:0] xw(input logic signed [W-1:0] x);
    return AW'(x);
  endfunction

  function automatic logic signed [AW-1:0] x32(input logic signed [31:0] x);
    return AW'(x);
  endfunction

  function automatic logic signed [AW-1:0] xu(input logic [30:0] x);
    return AW'({1'b0, x});
  endfunction

  // configuration
  logic [30:0]        dt;
  logic [30:0]        q_angle;
  logic [30:0]        q_bias;
  logic [30:0]        r_meas;
  logic signed [31:0] c0;

  // filter state and scratch
  state_t             state;
  logic               op_started;
  logic signed [31:0] meas;
  logic signed [31:0] rate;
  logic signed [W-1:0] angle;
  logic signed [W-1:0] bias;
  logic signed [W-1:0] c00;
  logic signed [W-1:0] c01;
  logic signed [W-1:0] c10;
  logic signed [W-1:0] c11;
  logic signed [W-1:0] tmp;
  logic signed [W-1:0] err;
  logic signed [W-1:0] pct0;
  logic signed [W-1:0] pct1;
  logic signed [W-1:0] k0;
  logic signed [W-1:0] k1;

  // shared units
  logic                 is_mul;
  logic                 is_div;
  logic                 mul_start;
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic                 mul_done;
  logic signed [W-1:0]  m;
  logic                 div_start;
  logic signed [W-1:0]  div_num;
  logic                 div_done;
  logic signed [W-1:0]  div_q;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // Select the unit and its operands (multiplier or divider) for the current step
  always_comb begin
    is_mul  = 1'b1;
    is_div  = 1'b0;
    mul_a   = MW'(tmp);
    mul_b   = MW'($signed({1'b0, dt}));
    div_num = pct0;
    case (state)
      S_M_ANG, S_M_C00, S_M_C01: ;
      S_M_C11:  mul_a = MW'($signed({1'b0, q_bias}));
      S_M_PCT0: begin mul_a = MW'(c0); mul_b = MW'(c00); end
      S_M_PCT1: begin mul_a = MW'(c0); mul_b = MW'(c10); end
      S_M_E:    begin mul_a = MW'(c0); mul_b = MW'(pct0); end
      S_M_T1:   begin mul_a = MW'(c0); mul_b = MW'(c01); end
      S_M_N00:  begin mul_a = MW'(k0); mul_b = MW'(pct0); end
      S_M_N01:  begin mul_a = MW'(k0); mul_b = MW'(tmp); end
      S_M_N10:  begin mul_a = MW'(k1); mul_b = MW'(pct0); end
      S_M_N11:  begin mul_a = MW'(k1); mul_b = MW'(tmp); end
      S_M_ANG2: begin mul_a = MW'(k0); mul_b = MW'(err); end
      S_M_BIAS: begin mul_a = MW'(k1); mul_b = MW'(err); end
      S_D_K0:   begin is_mul = 1'b0; is_div = 1'b1; end
      S_D_K1:   begin is_mul = 1'b0; is_div = 1'b1; div_num = pct1; end
      default:  is_mul = 1'b0;
    endcase
  end

  assign mul_start = is_mul && !op_started;
  assign div_start = is_div && !op_started && (tmp > 0);

  tkf_mul #(.VALUE_WIDTH(W), .MAG_WIDTH(MW)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (m)
  );

  tkf_div #(.VALUE_WIDTH(W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (tmp),
    .done  (div_done),
    .quot  (div_q)
  );

  // Sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      op_started <= 1'b0;
      out_valid  <= 1'b0;
      dt         <= RST_SAMPLE_PERIOD;
      q_angle    <= RST_ANGLE_NOISE;
      q_bias     <= RST_BIAS_NOISE;
      r_meas     <= RST_MEAS_NOISE;
      c0         <= RST_OBS_GAIN;
      angle      <= '0;
      bias       <= '0;
      c00        <= COV_ONE;
      c01        <= '0;
      c10        <= '0;
      c11        <= COV_ONE;
    end else begin
      // drop the result once taken; S_OUT reloads it on its own
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLE_PERIOD: dt      <= cfg_data[30:0];
          REG_ANGLE_NOISE:   q_angle <= cfg_data[30:0];
          REG_BIAS_NOISE:    q_bias  <= cfg_data[30:0];
          REG_MEAS_NOISE:    r_meas  <= cfg_data[30:0];
          REG_OBS_GAIN:      c0      <= cfg_data;
          default: ;
        endcase
      end

      if (mul_start || div_start) op_started <= 1'b1;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            meas  <= measured_angle;
            rate  <= angular_rate;
            state <= S_RB;
          end
        end
        S_RB: begin
          tmp   <= sat_w(x32(rate) - xw(bias));
          state <= S_M_ANG;
        end
        S_ERR: begin
          err   <= sat_w(x32(meas) - xw(angle));
          tmp   <= sat_w(xu(q_angle) - xw(c01) - xw(c10));
          state <= S_M_C00;
        end
        S_NEG: begin
          tmp   <= sat_w(-xw(c11));
          state <= S_M_C01;
        end
        S_D_K0, S_D_K1: begin
          if (!op_started && !(tmp > 0)) begin
            // innovation variance not positive: no correction
            k0    <= '0;
            k1    <= '0;
            state <= S_M_T1;
          end else if (div_done) begin
            op_started <= 1'b0;
            if (state == S_D_K0) begin
              k0    <= div_q;
              state <= S_D_K1;
            end else begin
              k1    <= div_q;
              state <= S_M_T1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            estimated_angle <= sat_32(xw(angle));
            estimated_rate  <= sat_32(x32(rate) - xw(bias));
            out_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          // multiplier steps: write back when the product arrives
          if (is_mul && mul_done) begin
            op_started <= 1'b0;
            case (state)
              S_M_ANG:  begin angle <= sat_w(xw(angle) + xw(m)); state <= S_ERR; end
              S_M_C00:  begin c00 <= sat_w(xw(c00) + xw(m)); state <= S_NEG; end
              S_M_C01: begin
                c01   <= sat_w(xw(c01) + xw(m));
                c10   <= sat_w(xw(c10) + xw(m));
                state <= S_M_C11;
              end
              S_M_C11:  begin c11 <= sat_w(xw(c11) + xw(m)); state <= S_M_PCT0; end
              S_M_PCT0: begin pct0 <= m; state <= S_M_PCT1; end
              S_M_PCT1: begin pct1 <= m; state <= S_M_E; end
              S_M_E:    begin tmp <= sat_w(xu(r_meas) + xw(m)); state <= S_D_K0; end
              S_M_T1:   begin tmp <= m; state <= S_M_N00; end
              S_M_N00:  begin c00 <= sat_w(xw(c00) - xw(m)); state <= S_M_N01; end
              S_M_N01:  begin c01 <= sat_w(xw(c01) - xw(m)); state <= S_M_N10; end
              S_M_N10:  begin c10 <= sat_w(xw(c10) - xw(m)); state <= S_M_N11; end
              S_M_N11:  begin c11 <= sat_w(xw(c11) - xw(m)); state <= S_M_ANG2; end
              S_M_ANG2: begin angle <= sat_w(xw(angle) + xw(m)); state <= S_M_BIAS; end
              S_M_BIAS: begin bias <= sat_w(xw(bias) + xw(m)); state <= S_OUT; end
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  `TKF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `TKF_ASSERT_IMPLIES(a_gain_zero, state == S_M_T1 && !(tmp > 0), k0 == '0 && k1 == '0)
  `TKF_ASSERT_IMPLIES(a_one_unit, mul_start, !div_start)
endmodule
`default_nettype wire
